// ===== src/cluster_aabb_classifier_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cluster bounding box classifier
// Shared concurrent assertion forms used by the core's submodules.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_AABB_CLASSIFIER_CORE_ASSERT_SVH
`define CLUSTER_AABB_CLASSIFIER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cac_pkg.sv =====
// ----------------------------------------------------------------------------
// cac_pkg
// Types, sizes and register codes shared by the cluster classifier modules.
// ----------------------------------------------------------------------------
package cac_pkg;

   localparam int MAX_POINTS   = 4096;
   localparam int MAX_CLUSTERS = 1024;
   localparam int COORD_BITS   = 16;

   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int CIDX_W  = $clog2(MAX_CLUSTERS);
   localparam int SUM_W   = COORD_BITS + $clog2(MAX_POINTS);
   localparam int REM_W   = CNT_W + 1;
   localparam int STEP_W  = $clog2(SUM_W);
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_POINTS = 3'd0,
      CSR_SIZE_X_MIN = 3'd1,
      CSR_SIZE_X_MAX = 3'd2,
      CSR_SIZE_Y_MIN = 3'd3,
      CSR_SIZE_Y_MAX = 3'd4,
      CSR_SIZE_Z_MIN = 3'd5,
      CSR_SIZE_Z_MAX = 3'd6
   } csr_index_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      point_valid;
      logic      cluster_last;
   } req_type;

   typedef struct packed {
      logic [CIDX_W-1:0] cluster_index;
      coord_type         box_min_x;
      coord_type         box_min_y;
      coord_type         box_min_z;
      coord_type         box_max_x;
      coord_type         box_max_y;
      coord_type         box_max_z;
      coord_type         center_x;
      coord_type         center_y;
      coord_type         center_z;
      logic [CNT_W-1:0]  point_count;
      logic              is_candidate;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]      min_points;
      logic [COORD_BITS-1:0] size_x_min;
      logic [COORD_BITS-1:0] size_x_max;
      logic [COORD_BITS-1:0] size_y_min;
      logic [COORD_BITS-1:0] size_y_max;
      logic [COORD_BITS-1:0] size_z_min;
      logic [COORD_BITS-1:0] size_z_max;
   } cfg_type;

   // One finished cluster handed from the accumulator to the divider.
   typedef struct packed {
      logic [CIDX_W-1:0]  cluster_index;
      coord_type [2:0]    lo;
      coord_type [2:0]    hi;
      sum_type [2:0]      sum;
      logic [CNT_W-1:0]   count;
   } job_type;

   // Queue status seen by the two sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ===== src/cluster_aabb_classifier_core.sv =====
// Cluster bounding box classifier. Points stream in on the req channel, one word
// per cycle with no stall while the job queue has room; each valid point is folded
// into per-cluster sums, box corners and a count, and the word with cluster_last
// closes the cluster. A non-empty cluster yields one rsp word with the box, the
// centroid truncated toward zero, the count and the candidate flag; an empty one
// yields nothing but still takes a cluster index. The centroid comes from a shared
// restoring divider that retires one quotient bit per cycle on all three axes.
// A two-entry queue lets the accumulator keep taking points while the divider
// works; req_stall rises only when that queue is full, so closing clusters faster
// than the back end finishes them will stall the input.
// The csr port is always ready; write the window registers only while idle.
// ----------------------------------------------------------------------------
// cluster_aabb_classifier_core
// Top level: configuration registers, accumulator, job queue and finisher.
// ----------------------------------------------------------------------------
module cluster_aabb_classifier_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cac_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cac_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cac_pkg::*;

   cfg_type        cfg_ff;
   queue_stat_type q_stat;
   logic           push;
   logic           pop;
   job_type        push_job;
   job_type        pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_points <= CNT_W'(10);
         cfg_ff.size_x_min <= COORD_BITS'(300);
         cfg_ff.size_x_max <= COORD_BITS'(8000);
         cfg_ff.size_y_min <= COORD_BITS'(200);
         cfg_ff.size_y_max <= COORD_BITS'(4000);
         cfg_ff.size_z_min <= COORD_BITS'(100);
         cfg_ff.size_z_max <= COORD_BITS'(3000);
      end else if (csr_valid && csr_ready) begin
         // Indexes past the register list are dropped.
         unique case (csr_index)
            CSR_MIN_POINTS: cfg_ff.min_points <= csr_wdata[CNT_W-1:0];
            CSR_SIZE_X_MIN: cfg_ff.size_x_min <= csr_wdata[COORD_BITS-1:0];
            CSR_SIZE_X_MAX: cfg_ff.size_x_max <= csr_wdata[COORD_BITS-1:0];
            CSR_SIZE_Y_MIN: cfg_ff.size_y_min <= csr_wdata[COORD_BITS-1:0];
            CSR_SIZE_Y_MAX: cfg_ff.size_y_max <= csr_wdata[COORD_BITS-1:0];
            CSR_SIZE_Z_MIN: cfg_ff.size_z_min <= csr_wdata[COORD_BITS-1:0];
            CSR_SIZE_Z_MAX: cfg_ff.size_z_max <= csr_wdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   cac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   cac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   cac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/cac_front.sv =====
// ----------------------------------------------------------------------------
// cac_front
// Point accumulator: folds valid points into sums, box corners and a count,
// and hands each non-empty cluster to the queue at its last point.
// ----------------------------------------------------------------------------
`include "cluster_aabb_classifier_core_assert.svh"

module cac_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cac_pkg::req_type        req_data,
   input  cac_pkg::queue_stat_type q_stat,
   output logic                    push,
   output cac_pkg::job_type        push_job
);
   import cac_pkg::*;

   logic [CIDX_W-1:0] cidx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   sum_type           sum_ff [3];
   coord_type         lo_ff  [3];
   coord_type         hi_ff  [3];

   logic [CNT_W-1:0]  cnt_in;
   sum_type           sum_in [3];
   coord_type         lo_in  [3];
   coord_type         hi_in  [3];
   coord_type         pt     [3];
   logic              take;
   logic              use_pt;

   assign pt[0] = req_data.point_x;
   assign pt[1] = req_data.point_y;
   assign pt[2] = req_data.point_z;

   // A full queue holds off every word, which keeps the rule simple.
   assign req_stall = q_stat.full;
   assign take      = req_valid && !req_stall;
   assign use_pt    = req_data.point_valid && (cnt_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = use_pt ? sum_ff[a] + SUM_W'(pt[a]) : sum_ff[a];
         lo_in[a]  = (use_pt && (pt[a] < lo_ff[a])) ? pt[a] : lo_ff[a];
         hi_in[a]  = (use_pt && (pt[a] > hi_ff[a])) ? pt[a] : hi_ff[a];
      end
      cnt_in = cnt_ff + CNT_W'(use_pt);
   end

   assign push = take && req_data.cluster_last && (cnt_in != '0);

   always_comb begin
      push_job.cluster_index = cidx_ff;
      push_job.count         = cnt_in;
      for (int a = 0; a < 3; a++) begin
         push_job.lo[a]  = lo_in[a];
         push_job.hi[a]  = hi_in[a];
         push_job.sum[a] = sum_in[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cidx_ff <= '0;
         cnt_ff  <= '0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
            lo_ff[a]  <= COORD_MAX;
            hi_ff[a]  <= COORD_MIN;
         end
      end else if (take) begin
         if (req_data.cluster_last) begin
            cidx_ff <= (cidx_ff == CIDX_W'(MAX_CLUSTERS - 1)) ? '0 : cidx_ff + 1'b1;
            cnt_ff  <= '0;
            for (int a = 0; a < 3; a++) begin
               sum_ff[a] <= '0;
               lo_ff[a]  <= COORD_MAX;
               hi_ff[a]  <= COORD_MIN;
            end
         end else begin
            cnt_ff <= cnt_in;
            for (int a = 0; a < 3; a++) begin
               sum_ff[a] <= sum_in[a];
               lo_ff[a]  <= lo_in[a];
               hi_ff[a]  <= hi_in[a];
            end
         end
      end
   end

   `CAC_ASSERT_NEXT(a_front_clear, clock, reset, take && req_data.cluster_last, cnt_ff == '0, "accumulator not cleared after last word")

endmodule

// ===== src/cac_queue.sv =====
// ----------------------------------------------------------------------------
// cac_queue
// Short job queue between the accumulator and the divider.
// ----------------------------------------------------------------------------
`include "cluster_aabb_classifier_core_assert.svh"

module cac_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cac_pkg::job_type        push_job,
   input  logic                    pop,
   output cac_pkg::job_type        pop_job,
   output cac_pkg::queue_stat_type q_stat
);
   import cac_pkg::*;

   job_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign q_stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_job      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `CAC_ASSERT_NOW(a_queue_overflow, clock, reset, push && q_stat.full, pop, "job pushed into a full queue")
   `CAC_ASSERT_NOW(a_queue_underflow, clock, reset, pop, !q_stat.empty, "job popped from an empty queue")

endmodule

// ===== src/cac_back.sv =====
// ----------------------------------------------------------------------------
// cac_back
// Cluster finisher: divides the three sums by the count one quotient bit a
// cycle, classifies the box and holds the result word for the consumer.
// ----------------------------------------------------------------------------
`include "cluster_aabb_classifier_core_assert.svh"

module cac_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cac_pkg::cfg_type        cfg,
   input  cac_pkg::queue_stat_type q_stat,
   input  cac_pkg::job_type        pop_job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cac_pkg::rsp_type        rsp_data
);
   import cac_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   job_type           job_ff;
   logic [SUM_W-1:0]  quo_ff [3];
   logic [REM_W-1:0]  rem_ff [3];
   logic              neg_ff [3];
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic [SUM_W-1:0]  mag    [3];
   logic [REM_W-1:0]  trial  [3];
   logic              fits   [3];
   coord_type         center [3];
   logic [COORD_BITS:0] ext  [3];
   logic [COORD_BITS-1:0] wmin [3];
   logic [COORD_BITS-1:0] wmax [3];
   logic              cand;
   logic              out_free;
   logic              load_out;
   rsp_type           out_in;

   assign pop      = (state_ff == S_IDLE) && !q_stat.empty;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign load_out = (state_ff == S_DONE) && out_free;

   assign wmin[0] = cfg.size_x_min;
   assign wmax[0] = cfg.size_x_max;
   assign wmin[1] = cfg.size_y_min;
   assign wmax[1] = cfg.size_y_max;
   assign wmin[2] = cfg.size_z_min;
   assign wmax[2] = cfg.size_z_max;

   always_comb begin
      cand = (job_ff.count >= cfg.min_points);
      for (int a = 0; a < 3; a++) begin
         mag[a] = pop_job.sum[a][SUM_W-1] ? (~pop_job.sum[a] + 1'b1) : pop_job.sum[a];
         // Restoring division: bring down the next dividend bit and try a subtract.
         trial[a] = {rem_ff[a][REM_W-2:0], quo_ff[a][SUM_W-1]};
         fits[a]  = (trial[a] >= REM_W'(job_ff.count));
         center[a] = neg_ff[a] ? -coord_type'(quo_ff[a][COORD_BITS-1:0])
                               : coord_type'(quo_ff[a][COORD_BITS-1:0]);
         // The box is never empty here, so the extent is not negative.
         ext[a] = {job_ff.hi[a][COORD_BITS-1], job_ff.hi[a]}
                - {job_ff.lo[a][COORD_BITS-1], job_ff.lo[a]};
         cand = cand && (ext[a] >= {1'b0, wmin[a]}) && (ext[a] <= {1'b0, wmax[a]});
      end
   end

   always_comb begin
      out_in.cluster_index = job_ff.cluster_index;
      out_in.box_min_x     = job_ff.lo[0];
      out_in.box_min_y     = job_ff.lo[1];
      out_in.box_min_z     = job_ff.lo[2];
      out_in.box_max_x     = job_ff.hi[0];
      out_in.box_max_y     = job_ff.hi[1];
      out_in.box_max_z     = job_ff.hi[2];
      out_in.center_x      = center[0];
      out_in.center_y      = center[1];
      out_in.center_z      = center[2];
      out_in.point_count   = job_ff.count;
      out_in.is_candidate  = cand;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // A new word may replace the held one in the cycle it is taken.
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  job_ff  <= pop_job;
                  step_ff <= STEP_W'(SUM_W - 1);
                  for (int a = 0; a < 3; a++) begin
                     quo_ff[a] <= mag[a];
                     rem_ff[a] <= '0;
                     neg_ff[a] <= pop_job.sum[a][SUM_W-1];
                  end
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               for (int a = 0; a < 3; a++) begin
                  rem_ff[a] <= fits[a] ? trial[a] - REM_W'(job_ff.count) : trial[a];
                  quo_ff[a] <= {quo_ff[a][SUM_W-2:0], fits[a]};
               end
               if (step_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            S_DONE: begin
               if (load_out) begin
                  out_ff   <= out_in;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `CAC_ASSERT_NOW(a_back_nonempty, clock, reset, state_ff == S_DIV, job_ff.count != '0, "empty cluster reached the divider")
   `CAC_ASSERT_NEXT(a_back_start, clock, reset, pop, state_ff == S_DIV && step_ff == STEP_W'(SUM_W - 1), "division did not start after pop")

endmodule

// ===== tb/sv/tb_cluster_aabb_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_aabb_classifier_core
// Self-checking bench for the cluster bounding box classifier. Point words are
// streamed from a queue into the req channel. Every accepted point is folded
// into a local box model, which queues the box word due at each closing point.
// Each rsp word is checked field by field against the oldest queued box. Runs
// go through several window settings, written only while the core is idle.
// ----------------------------------------------------------------------------
module tb_cluster_aabb_classifier_core;
   import cac_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 2 * (SUM_W + 2);
   localparam int WORDS_PER_RUN  = 160;
   localparam int REQ_W          = $bits(req_type);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   localparam cfg_type CFG_AT_RESET = '{min_points: 10,
                                        size_x_min: 300, size_x_max: 8000,
                                        size_y_min: 200, size_y_max: 4000,
                                        size_z_min: 100, size_z_max: 3000};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Box model state.
   cfg_type           win_cfg;
   logic [CIDX_W-1:0] cluster_seq;
   longint            acc_sum[3];
   int                lo_c[3];
   int                hi_c[3];
   int unsigned       pts;

   req_type points_to_send[$];
   rsp_type boxes_due[$];

   int errors = 0;
   int cycle_count = 0;
   int phase_words = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int req_gap = 0;
   int rsp_hold = 0;

   cluster_aabb_classifier_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   function automatic void clear_cluster();
      for (int a = 0; a < 3; a++) begin
         acc_sum[a] = 0;
         lo_c[a] = int'(COORD_MAX);
         hi_c[a] = int'(COORD_MIN);
      end
      pts = 0;
   endfunction

   function automatic bit in_window(input int v, input int lo, input int hi);
      return v >= lo && v <= hi;
   endfunction

   // Folds one accepted point word into the model and queues the box word
   // that a closing point of a non-empty cluster produces.
   function automatic void fold_point(input req_type w);
      int      c[3];
      int      ext[3];
      longint  n;
      rsp_type r;
      c[0] = w.point_x;
      c[1] = w.point_y;
      c[2] = w.point_z;
      if (w.point_valid && pts < MAX_POINTS) begin
         for (int a = 0; a < 3; a++) begin
            acc_sum[a] += c[a];
            if (c[a] < lo_c[a]) lo_c[a] = c[a];
            if (c[a] > hi_c[a]) hi_c[a] = c[a];
         end
         pts++;
      end
      if (w.cluster_last) begin
         if (pts > 0) begin
            n = pts;
            for (int a = 0; a < 3; a++) ext[a] = hi_c[a] - lo_c[a];
            r.cluster_index = cluster_seq;
            r.box_min_x     = coord_type'(lo_c[0]);
            r.box_min_y     = coord_type'(lo_c[1]);
            r.box_min_z     = coord_type'(lo_c[2]);
            r.box_max_x     = coord_type'(hi_c[0]);
            r.box_max_y     = coord_type'(hi_c[1]);
            r.box_max_z     = coord_type'(hi_c[2]);
            r.center_x      = coord_type'(acc_sum[0] / n);
            r.center_y      = coord_type'(acc_sum[1] / n);
            r.center_z      = coord_type'(acc_sum[2] / n);
            r.point_count   = pts[CNT_W-1:0];
            r.is_candidate  = pts >= win_cfg.min_points
               && in_window(ext[0], int'(win_cfg.size_x_min), int'(win_cfg.size_x_max))
               && in_window(ext[1], int'(win_cfg.size_y_min), int'(win_cfg.size_y_max))
               && in_window(ext[2], int'(win_cfg.size_z_min), int'(win_cfg.size_z_max));
            boxes_due = {boxes_due, r};
         end
         cluster_seq++;
         clear_cluster();
      end
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         errors++;
         $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function automatic void check_box(input rsp_type want, input rsp_type got);
      check_field("cluster_index", want.cluster_index, got.cluster_index);
      check_field("box_min_x", want.box_min_x, got.box_min_x);
      check_field("box_min_y", want.box_min_y, got.box_min_y);
      check_field("box_min_z", want.box_min_z, got.box_min_z);
      check_field("box_max_x", want.box_max_x, got.box_max_x);
      check_field("box_max_y", want.box_max_y, got.box_max_y);
      check_field("box_max_z", want.box_max_z, got.box_max_z);
      check_field("center_x", want.center_x, got.center_x);
      check_field("center_y", want.center_y, got.center_y);
      check_field("center_z", want.center_z, got.center_z);
      check_field("point_count", want.point_count, got.point_count);
      check_field("is_candidate", want.is_candidate, got.is_candidate);
   endfunction

   // Point driver: holds the word while stalled, otherwise idles in bursts or
   // presents the next pending word.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (points_to_send.size() != 0 && $urandom_range(99) < req_idle_pct) begin
            req_gap = $urandom_range(4);
            req_valid <= 1'b0;
         end else if (points_to_send.size() != 0) begin
            req_data <= points_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < rsp_idle_pct) begin
         rsp_hold = $urandom_range(4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            if (req_valid && !req_stall) fold_point(req_data);
            if (rsp_valid && !rsp_stall) begin
               if (boxes_due.size() == 0) begin
                  errors++;
                  $display("[%0t] unexpected box word: expected none, got cluster %0d",
                           $time, rsp_data.cluster_index);
               end else begin
                  check_box(boxes_due.pop_front(), rsp_data);
               end
            end
         end
      end
   end

   function automatic void push_word(input req_type w);
      points_to_send = {points_to_send, w};
      phase_words++;
   endfunction

   function automatic req_type point_word(input int x, input int y, input int z,
                                          input bit valid, input bit last);
      req_type w;
      w.point_x      = coord_type'(x);
      w.point_y      = coord_type'(y);
      w.point_z      = coord_type'(z);
      w.point_valid  = valid;
      w.cluster_last = last;
      return w;
   endfunction

   // One random cluster: per-axis spans from zero to the full range, stray
   // invalid points inside, sometimes closed by an invalid word, sometimes empty.
   task automatic queue_random_cluster();
      req_type     w;
      int unsigned span[3];
      int          base[3];
      int          n;
      int          k;
      bit          tail_invalid;
      case ($urandom_range(19))
         0: n = 0;
         1, 2, 3: n = $urandom_range(20, 7);
         4: n = $urandom_range(60, 21);
         default: n = $urandom_range(6, 1);
      endcase
      for (int a = 0; a < 3; a++) begin
         case ($urandom_range(3))
            0: span[a] = 0;
            1: span[a] = $urandom_range(400);
            2: span[a] = $urandom_range(9000);
            default: span[a] = $urandom_range(65535);
         endcase
         base[a] = int'($urandom_range(65535 - span[a])) - 32768;
      end
      tail_invalid = (n == 0) || ($urandom_range(4) == 0);
      k = 0;
      while (k < n) begin
         w = REQ_W'({$urandom, $urandom});
         if ($urandom_range(9) == 0) begin
            w.point_valid  = 1'b0;
            w.cluster_last = 1'b0;
         end else begin
            w.point_x      = coord_type'(base[0] + $urandom_range(span[0]));
            w.point_y      = coord_type'(base[1] + $urandom_range(span[1]));
            w.point_z      = coord_type'(base[2] + $urandom_range(span[2]));
            w.point_valid  = 1'b1;
            k++;
            w.cluster_last = (k == n) && !tail_invalid;
         end
         push_word(w);
      end
      if (tail_invalid) begin
         w = REQ_W'({$urandom, $urandom});
         w.point_valid  = 1'b0;
         w.cluster_last = 1'b1;
         push_word(w);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_POINTS: win_cfg.min_points = val[CNT_W-1:0];
         CSR_SIZE_X_MIN: win_cfg.size_x_min = val;
         CSR_SIZE_X_MAX: win_cfg.size_x_max = val;
         CSR_SIZE_Y_MIN: win_cfg.size_y_min = val;
         CSR_SIZE_Y_MAX: win_cfg.size_y_max = val;
         CSR_SIZE_Z_MIN: win_cfg.size_z_min = val;
         CSR_SIZE_Z_MAX: win_cfg.size_z_max = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_windows(input cfg_type c);
      write_reg(CSR_MIN_POINTS, CSR_DATA_W'(c.min_points));
      write_reg(CSR_SIZE_X_MIN, c.size_x_min);
      write_reg(CSR_SIZE_X_MAX, c.size_x_max);
      write_reg(CSR_SIZE_Y_MIN, c.size_y_min);
      write_reg(CSR_SIZE_Y_MAX, c.size_y_max);
      write_reg(CSR_SIZE_Z_MIN, c.size_z_min);
      write_reg(CSR_SIZE_Z_MAX, c.size_z_max);
   endtask

   // Waits until every word is sent and every box has come back, then lets
   // the divider back end run out.
   task automatic wait_drained();
      while (points_to_send.size() != 0 || req_valid || boxes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      cfg_type c;
      win_cfg     = CFG_AT_RESET;
      cluster_seq = '0;
      clear_cluster();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset windows.
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      push_word(point_word(32767, 32767, 32767, 1'b1, 1'b1));
      push_word(point_word(-32768, -32768, -32768, 1'b1, 1'b1));
      // Full-range extents; the centroid of -1/2 truncates to zero.
      push_word(point_word(-32768, -32768, -32768, 1'b1, 1'b0));
      push_word(point_word(32767, 32767, 32767, 1'b1, 1'b1));
      // An empty cluster still takes an index.
      push_word(point_word(-32768, 32767, -1, 1'b0, 1'b1));
      // Closed by an invalid word whose coordinates must be ignored.
      push_word(point_word(-5, 7, -9, 1'b1, 1'b0));
      push_word(point_word(3, -2, 11, 1'b1, 1'b0));
      push_word(point_word(-1, 0, 4, 1'b1, 1'b0));
      push_word(point_word(32767, -32768, 32767, 1'b0, 1'b1));
      // Exactly min_points points, each extent on a window edge.
      for (int i = 0; i < 10; i++) begin
         push_word(point_word(-1000 + (i * 300) / 9, 1234 - (i * 4000) / 9,
                              -5 + (i * 100) / 9, 1'b1, i == 9));
         if (i == 4) push_word(point_word(32767, -32768, 32767, 1'b0, 1'b0));
      end

      for (int ph = 1; ph <= 9; ph++) begin
         wait_drained();
         case (ph)
            1: ;
            2: program_windows('0);
            3: begin
               c = '{min_points: CNT_W'(MAX_POINTS), size_x_min: 0, size_x_max: 16'hFFFF,
                     size_y_min: 0, size_y_max: 16'hFFFF,
                     size_z_min: 0, size_z_max: 16'hFFFF};
               program_windows(c);
            end
            4: begin
               // Oversized count truncates to the register width; the
               // unmapped index must leave everything alone.
               write_reg(CSR_MIN_POINTS, 16'hFFFF);
               write_reg(CSR_UNMAPPED, 16'h0001);
            end
            5: begin
               c = '{min_points: 0, size_x_min: 5000, size_x_max: 100,
                     size_y_min: 0, size_y_max: 16'hFFFF,
                     size_z_min: 0, size_z_max: 16'hFFFF};
               program_windows(c);
            end
            default: begin
               c.min_points = CNT_W'($urandom_range(12));
               c.size_x_min = COORD_BITS'($urandom_range(2000));
               c.size_x_max = c.size_x_min + COORD_BITS'($urandom_range(30000));
               c.size_y_min = COORD_BITS'($urandom_range(2000));
               c.size_y_max = c.size_y_min + COORD_BITS'($urandom_range(30000));
               c.size_z_min = COORD_BITS'($urandom_range(2000));
               c.size_z_max = c.size_z_min + COORD_BITS'($urandom_range(30000));
               program_windows(c);
            end
         endcase
         req_idle_pct = (ph == 9) ? 0 : 25 * $urandom_range(2);
         rsp_idle_pct = (ph == 9) ? 0 : 25 * $urandom_range(2);
         phase_words = 0;
         while (phase_words < WORDS_PER_RUN) queue_random_cluster();
      end
      wait_drained();

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/cac_pkg.sv
src/cac_front.sv
src/cac_queue.sv
src/cac_back.sv
src/cluster_aabb_classifier_core.sv
tb/sv/tb_cluster_aabb_classifier_core.sv
